[hdl/cpwlt_pkg.sv]
package cpwlt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field formats.
  localparam int CFG_W   = 7;
  localparam int INDEX_W = 6;
  localparam int ANGLE_W = 16;
  localparam int VAL_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * (VAL_W + 1);

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [VAL_W-1:0]   lift;
    logic signed [VAL_W-1:0]   drag;
  } bp_t;

  typedef struct packed {
    func_e                     func;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [ANGLE_W-1:0] entry_angle;
    logic signed [VAL_W-1:0]   entry_lift;
    logic signed [VAL_W-1:0]   entry_drag;
    logic signed [ANGLE_W-1:0] query_angle;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] lift;
    logic signed [VAL_W-1:0] drag;
    logic signed [VAL_W-1:0] max_lift;
  } res_t;

endpackage

[hdl/cpwlt_if.sv]
interface cpwlt_req_if;
  import cpwlt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [ANGLE_W-1:0] entry_angle;
  logic signed [VAL_W-1:0]   entry_lift;
  logic signed [VAL_W-1:0]   entry_drag;
  logic signed [ANGLE_W-1:0] query_angle;

  modport source (
    output valid, func, entry_index, entry_angle, entry_lift, entry_drag, query_angle,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_angle, entry_lift, entry_drag, query_angle,
    output ready
  );
endinterface

interface cpwlt_rsp_if;
  import cpwlt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] lift;
  logic signed [VAL_W-1:0] drag;
  logic signed [VAL_W-1:0] max_lift;

  modport source (
    output valid, lift, drag, max_lift,
    input  ready
  );
  modport sink (
    input  valid, lift, drag, max_lift,
    output ready
  );
endinterface

interface cpwlt_cfg_if;
  import cpwlt_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

[hdl/cpwlt_div.sv]
module cpwlt_div import cpwlt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ANGLE_W-1:0] num_i,
  input  logic [ANGLE_W-1:0] den_i,
  output logic               done_o,
  output logic [FRAC_W-1:0]  quot_o
);

  // Restoring division of (num << FRAC_W) by den, one quotient bit per cycle.
  // The caller guarantees num < den, so the remainder always fits.
  localparam int StepW = $clog2(FRAC_W + 1);

  logic               busy_q;
  logic               done_q;
  logic [StepW-1:0]   step_q;
  logic [ANGLE_W-1:0] rem_q;
  logic [ANGLE_W-1:0] den_q;
  logic [FRAC_W-1:0]  quot_q;

  logic [ANGLE_W:0]   shifted;
  logic [ANGLE_W:0]   reduced;
  logic               fits;

  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, den_q};
  assign reduced = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == StepW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(FRAC_W);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? reduced[ANGLE_W-1:0] : shifted[ANGLE_W-1:0];
      quot_q <= {quot_q[FRAC_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[hdl/cpwlt_core.sv]
module cpwlt_core import cpwlt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  input  logic [CNT_W-1:0] used_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int AngW = ANGLE_W + 1;
  localparam int DifW = VAL_W + 1;
  localparam int SumW = PROD_W - FRAC_W;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_CL0  = 13'b0000000000010,
    S_CL1  = 13'b0000000000100,
    S_SRCH = 13'b0000000001000,
    S_SCMP = 13'b0000000010000,
    S_PICK = 13'b0000000100000,
    S_RA   = 13'b0000001000000,
    S_RB   = 13'b0000010000000,
    S_DIV  = 13'b0000100000000,
    S_MUL  = 13'b0001000000000,
    S_ADD  = 13'b0010000000000,
    S_SCAN = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // Breakpoint memory: one write port, one read port, registered read data.
  bp_t              mem_q [TABLE_DEPTH];
  bp_t              rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  bp_t              mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  logic signed [ANGLE_W-1:0] q_q, q_d;
  logic [CNT_W-1:0]          lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]          mid_q, mid_d;
  bp_t                       p1_q, p1_d;
  logic signed [DifW-1:0]    diff_l_q, diff_l_d, diff_d_q, diff_d_d;
  logic signed [PROD_W-1:0]  prod_l_q, prod_l_d, prod_d_q, prod_d_d;
  logic signed [VAL_W-1:0]   res_lift_q, res_lift_d, res_drag_q, res_drag_d;
  logic signed [VAL_W-1:0]   max_q, max_d;
  logic                      max_first_q, max_first_d;
  logic [CNT_W-1:0]          scan_idx_q, scan_idx_d;
  logic                      scan_pend_q, scan_pend_d;

  logic [CNT_W-1:0]        last_idx;
  logic [CNT_W-1:0]        lo_m1;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;
  logic signed [AngW-1:0]  span;
  logic signed [AngW-1:0]  offs;
  logic signed [SumW-1:0]  sum_l;
  logic signed [SumW-1:0]  sum_d;

  logic              div_start;
  logic              div_done;
  logic [FRAC_W-1:0] div_quot;

  cpwlt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (offs[ANGLE_W-1:0]),
    .den_i   (span[ANGLE_W-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign last_idx = used_i - CNT_W'(1);
  assign lo_m1    = lo_q - CNT_W'(1);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[CNT_W:1];

  // Neighbor spacing and query offset, valid while the upper neighbor is on rdata.
  assign span = AngW'($signed(rdata_q.angle)) - AngW'($signed(p1_q.angle));
  assign offs = AngW'($signed(q_q)) - AngW'($signed(p1_q.angle));

  // Floor of the scaled product is its arithmetic upper half.
  assign sum_l = SumW'($signed(p1_q.lift)) + $signed(prod_l_q[PROD_W-1:FRAC_W]);
  assign sum_d = SumW'($signed(p1_q.drag)) + $signed(prod_d_q[PROD_W-1:FRAC_W]);

  always_comb begin
    state_d     = state_q;
    q_d         = q_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    p1_d        = p1_q;
    diff_l_d    = diff_l_q;
    diff_d_d    = diff_d_q;
    prod_l_d    = prod_l_q;
    prod_d_d    = prod_d_q;
    res_lift_d  = res_lift_q;
    res_drag_d  = res_drag_q;
    max_d       = max_q;
    max_first_d = max_first_q;
    scan_idx_d  = scan_idx_q;
    scan_pend_d = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = IDX_W'(req_i.entry_index);
    mem_wdata   = '{angle: req_i.entry_angle, lift: req_i.entry_lift,
                    drag: req_i.entry_drag};
    mem_re      = 1'b0;
    mem_raddr   = '0;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_i.func == FUNC_WRITE) begin
            mem_we     = int'(req_i.entry_index) < TABLE_DEPTH;
            res_lift_d = '0;
            res_drag_d = '0;
            state_d    = S_SCAN;
          end else begin
            q_d       = req_i.query_angle;
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_d   = S_CL0;
          end
        end
      end
      S_CL0: begin
        if (q_q < rdata_q.angle) begin
          q_d = rdata_q.angle;
        end
        mem_re    = 1'b1;
        mem_raddr = last_idx[IDX_W-1:0];
        state_d   = S_CL1;
      end
      S_CL1: begin
        if (q_q > rdata_q.angle) begin
          q_d = rdata_q.angle;
        end
        lo_d    = '0;
        hi_d    = used_i;
        state_d = S_SRCH;
      end
      S_SRCH: begin
        mem_re = 1'b1;
        if (lo_q < hi_q) begin
          mem_raddr = mid[IDX_W-1:0];
          mid_d     = mid[IDX_W-1:0];
          state_d   = S_SCMP;
        end else if (lo_q == '0) begin
          mem_raddr = '0;
          state_d   = S_PICK;
        end else if (lo_q >= used_i) begin
          mem_raddr = last_idx[IDX_W-1:0];
          state_d   = S_PICK;
        end else begin
          mem_raddr = lo_m1[IDX_W-1:0];
          state_d   = S_RA;
        end
      end
      S_SCMP: begin
        if (rdata_q.angle < q_q) begin
          lo_d = CNT_W'(mid_q) + CNT_W'(1);
        end else begin
          hi_d = CNT_W'(mid_q);
        end
        state_d = S_SRCH;
      end
      S_PICK: begin
        res_lift_d = rdata_q.lift;
        res_drag_d = rdata_q.drag;
        state_d    = S_SCAN;
      end
      S_RA: begin
        p1_d      = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = lo_q[IDX_W-1:0];
        state_d   = S_RB;
      end
      S_RB: begin
        if (span <= 0 || offs <= 0) begin
          res_lift_d = p1_q.lift;
          res_drag_d = p1_q.drag;
          state_d    = S_SCAN;
        end else if (offs >= span) begin
          res_lift_d = rdata_q.lift;
          res_drag_d = rdata_q.drag;
          state_d    = S_SCAN;
        end else begin
          diff_l_d  = DifW'($signed(rdata_q.lift)) - DifW'($signed(p1_q.lift));
          diff_d_d  = DifW'($signed(rdata_q.drag)) - DifW'($signed(p1_q.drag));
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_l_d = $signed({1'b0, div_quot}) * diff_l_q;
        prod_d_d = $signed({1'b0, div_quot}) * diff_d_q;
        state_d  = S_ADD;
      end
      S_ADD: begin
        res_lift_d = sum_l[VAL_W-1:0];
        res_drag_d = sum_d[VAL_W-1:0];
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx_q < used_i) begin
          mem_re      = 1'b1;
          mem_raddr   = scan_idx_q[IDX_W-1:0];
          scan_idx_d  = scan_idx_q + CNT_W'(1);
          scan_pend_d = 1'b1;
        end
        if (scan_pend_q) begin
          if (max_first_q || rdata_q.lift > max_q) begin
            max_d = rdata_q.lift;
          end
          max_first_d = 1'b0;
        end
        if (scan_idx_q >= used_i && !scan_pend_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Every item ends with a fresh sweep for the largest lift.
    if (state_d == S_SCAN && state_q != S_SCAN) begin
      scan_idx_d  = '0;
      scan_pend_d = 1'b0;
      max_first_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_pend_q <= scan_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q         <= q_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    p1_q        <= p1_d;
    diff_l_q    <= diff_l_d;
    diff_d_q    <= diff_d_d;
    prod_l_q    <= prod_l_d;
    prod_d_q    <= prod_d_d;
    res_lift_q  <= res_lift_d;
    res_drag_q  <= res_drag_d;
    max_q       <= max_d;
    max_first_q <= max_first_d;
    scan_idx_q  <= scan_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{lift: res_lift_q, drag: res_drag_q, max_lift: max_q};

endmodule

[hdl/clamped_piecewise_linear_table.sv]
// One request is in work at a time: a new request is taken only after the core has handed
// the result of the last one to the output register. One memory read port serves the clamp,
// the search probes and the lift sweep; a bit-serial divider forms the fraction. Reset is
// asynchronous and active low; it sets the entry count to 1 and leaves the breakpoint
// memory without a reset value.
module clamped_piecewise_linear_table import cpwlt_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  cpwlt_req_if.sink    req_i,
  cpwlt_rsp_if.source  rsp_o,
  cpwlt_cfg_if.sink    cfg_i
);

  // The configuration register is always ready. Software must write it only while the block
  // is idle so the core sees a stable count for a whole request; the block does not enforce it.
  logic [CFG_W-1:0] cfg_q;
  logic [CNT_W-1:0] used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      cfg_q <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;

  // A count of zero behaves as one entry, a count above the depth as the full table.
  always_comb begin
    if (cfg_q == '0) begin
      used = CNT_W'(1);
    end else if (int'(cfg_q) > TABLE_DEPTH) begin
      used = CNT_W'(TABLE_DEPTH);
    end else begin
      used = CNT_W'(cfg_q);
    end
  end

  // The core runs one request at a time through its memory-centered sequencer.
  req_t core_req;
  logic core_ready;
  logic core_res_valid;
  logic core_res_ready;
  res_t core_res;

  assign core_req = '{
    func:        func_e'(req_i.func),
    entry_index: req_i.entry_index,
    entry_angle: req_i.entry_angle,
    entry_lift:  req_i.entry_lift,
    entry_drag:  req_i.entry_drag,
    query_angle: req_i.query_angle
  };

  cpwlt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (core_ready),
    .req_i       (core_req),
    .used_i      (used),
    .res_valid_o (core_res_valid),
    .res_ready_i (core_res_ready),
    .res_o       (core_res)
  );

  assign req_i.ready = core_ready;

  // The output register holds the result for the sink: the core hands over its result and
  // returns to idle only once the register is empty or its result is being taken.
  logic out_valid_q;
  res_t out_q;

  assign core_res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_q <= core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_ready && core_res_valid) begin
      out_q <= core_res;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.lift     = out_q.lift;
  assign rsp_o.drag     = out_q.drag;
  assign rsp_o.max_lift = out_q.max_lift;

endmodule

[hdl/cpwlt_chk.sv]
module cpwlt_chk import cpwlt_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [VAL_W-1:0] out_lift_i,
  input logic signed [VAL_W-1:0] out_drag_i,
  input logic signed [VAL_W-1:0] out_max_lift_i
);

  // Requests accepted whose results have not yet been taken.
  logic [1:0] open_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_lift_i) && $stable(out_drag_i) && $stable(out_max_lift_i))
    else $error("result payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("new request taken while the previous one is in work");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q != 2'd3) && (!out_valid_i || open_q != 2'd0))
    else $error("result without an open request, or too many open requests");

endmodule

bind clamped_piecewise_linear_table cpwlt_chk u_cpwlt_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .out_lift_i     (rsp_o.lift),
  .out_drag_i     (rsp_o.drag),
  .out_max_lift_i (rsp_o.max_lift)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cpwlt_pkg::*;

  // Number of random requests after the directed opening.
  localparam int unsigned RANDOM_ITEMS = 1050;

  // Holds a private copy of the breakpoint table and the entry count, works out the result of
  // every accepted request and checks the block's results against them in order.
  class curve_scoreboard;
    int               ang [TABLE_DEPTH];
    int               lft [TABLE_DEPTH];
    int               drg [TABLE_DEPTH];
    logic [CFG_W-1:0] entries_cfg;
    res_t             expected_curves [$];
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      writes_seen;
    int unsigned      lookups_seen;
    int unsigned      blended;

    function new();
      foreach (ang[i]) begin
        ang[i] = 0;
        lft[i] = 0;
        drg[i] = 0;
      end
      entries_cfg = 1;
    endfunction

    function void set_entries(logic [CFG_W-1:0] v);
      entries_cfg = v;
    endfunction

    function int active_count();
      if (entries_cfg == 0) return 1;
      if (entries_cfg > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(entries_cfg);
    endfunction

    function int outstanding();
      return expected_curves.size();
    endfunction

    // Moves from v1 toward v2 by the 0.16 fraction, rounding toward minus infinity.
    function int blend(int v1, int v2, longint frac);
      longint prod;
      longint step;
      prod = frac * longint'(v2 - v1);
      if (prod >= 0) begin
        step = prod / 65536;
      end else begin
        step = -((-prod + 65535) / 65536);
      end
      return v1 + int'(step);
    endfunction

    function void note_request(req_t r);
      res_t   want;
      int     n;
      int     q;
      int     lo;
      int     hi;
      int     mid;
      int     d;
      int     e;
      int     lv;
      int     dv;
      int     peak;
      longint frac;
      n  = active_count();
      lv = 0;
      dv = 0;
      if (r.func == FUNC_WRITE) begin
        writes_seen++;
        ang[r.entry_index] = int'($signed(r.entry_angle));
        lft[r.entry_index] = int'($signed(r.entry_lift));
        drg[r.entry_index] = int'($signed(r.entry_drag));
      end else begin
        lookups_seen++;
        q = int'($signed(r.query_angle));
        if (q < ang[0]) q = ang[0];
        if (q > ang[n-1]) q = ang[n-1];
        lo = 0;
        hi = n;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (ang[mid] < q) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
        if (lo == 0) begin
          lv = lft[0];
          dv = drg[0];
        end else if (lo >= n) begin
          lv = lft[n-1];
          dv = drg[n-1];
        end else begin
          d = ang[lo] - ang[lo-1];
          e = q - ang[lo-1];
          if (d <= 0 || e <= 0) begin
            lv = lft[lo-1];
            dv = drg[lo-1];
          end else if (e >= d) begin
            lv = lft[lo];
            dv = drg[lo];
          end else begin
            frac = (longint'(e) <<< 16) / longint'(d);
            lv = blend(lft[lo-1], lft[lo], frac);
            dv = blend(drg[lo-1], drg[lo], frac);
            blended++;
          end
        end
      end
      peak = lft[0];
      for (int i = 1; i < n; i++) begin
        if (lft[i] > peak) peak = lft[i];
      end
      want.lift     = lv[VAL_W-1:0];
      want.drag     = dv[VAL_W-1:0];
      want.max_lift = peak[VAL_W-1:0];
      expected_curves.push_back(want);
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_curves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: unexpected result lift %0d drag %0d max_lift %0d",
                   got.lift, got.drag, got.max_lift);
        end
        return;
      end
      want = expected_curves.pop_front();
      if (got.lift !== want.lift || got.drag !== want.drag || got.max_lift !== want.max_lift)
      begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: mismatch on result %0d: expected lift %0d drag %0d max_lift %0d,",
                   results_seen, want.lift, want.drag, want.max_lift);
          $display("tb:   got lift %0d drag %0d max_lift %0d",
                   got.lift, got.drag, got.max_lift);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  cpwlt_req_if req_if ();
  cpwlt_rsp_if rsp_if ();
  cpwlt_cfg_if cfg_if ();

  clamped_piecewise_linear_table u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  curve_scoreboard sb = new();

  // What the stimulus has written so far. Lookups aim their queries at these angles, and an
  // entry count is only programmed once every entry it covers has been loaded, so the block
  // never reads a breakpoint that was never written.
  int          tab_angle [TABLE_DEPTH];
  bit          loaded    [TABLE_DEPTH];
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned rsp_cycle;
  int unsigned stall_mode;
  int unsigned mode_left;
  req_t        seen_req;
  res_t        seen_res;

  always #4 clk = ~clk;

  // The result side stalls on a pattern of its own: it switches now and then between always
  // ready, coin-flip ready, ready one cycle in four and ready one cycle in twelve.
  always @(negedge clk) begin
    rsp_cycle <= rsp_cycle + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
      2: rsp_if.ready <= (rsp_cycle % 4 == 0);
      default: rsp_if.ready <= (rsp_cycle % 12 == 0);
    endcase
  end

  // Every handshake is observed at the rising edge, where the values driven at the previous
  // falling edge and the block's registered outputs are both settled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_entries(cfg_if.data);
      if (req_if.valid && req_if.ready) begin
        seen_req.func        = func_e'(req_if.func);
        seen_req.entry_index = req_if.entry_index;
        seen_req.entry_angle = req_if.entry_angle;
        seen_req.entry_lift  = req_if.entry_lift;
        seen_req.entry_drag  = req_if.entry_drag;
        seen_req.query_angle = req_if.query_angle;
        sb.note_request(seen_req);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        seen_res.lift     = rsp_if.lift;
        seen_res.drag     = rsp_if.drag;
        seen_res.max_lift = rsp_if.max_lift;
        sb.check_result(seen_res);
      end
    end
  end

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // A curve value, with the two extremes of the format picked more often than chance would.
  function automatic int pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    return rand16();
  endfunction

  // A query angle: mostly inside the span of the loaded angles, some on or next to a
  // breakpoint, and some anywhere in the format so that the clamp is exercised.
  function automatic int pick_query(int eff);
    int lo_a;
    int hi_a;
    int k;
    lo_a = tab_angle[0];
    hi_a = tab_angle[eff-1];
    if (lo_a > hi_a) begin
      k    = lo_a;
      lo_a = hi_a;
      hi_a = k;
    end
    case ($urandom_range(0, 9))
      0, 1: return rand16();
      2, 3: begin
        k = tab_angle[$urandom_range(0, eff-1)] + int'($urandom_range(0, 2)) - 1;
        if (k < -32768) k = -32768;
        if (k > 32767) k = 32767;
        return k;
      end
      default: return lo_a + int'($urandom_range(0, hi_a - lo_a));
    endcase
  endfunction

  // Sends one request. The sender works in bursts; between bursts valid drops for a random
  // gap, long enough at times to land in any phase of a lookup.
  task automatic send_request(req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8, 9, 10, 11, 12: gap = $urandom_range(1, 8);
        default: gap = $urandom_range(9, 130);
      endcase
      if (gap != 0) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_if.valid       <= 1'b1;
    req_if.func        <= r.func;
    req_if.entry_index <= r.entry_index;
    req_if.entry_angle <= r.entry_angle;
    req_if.entry_lift  <= r.entry_lift;
    req_if.entry_drag  <= r.entry_drag;
    req_if.query_angle <= r.query_angle;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic load_entry(int idx, int a, int l, int d);
    req_t r;
    int   q;
    q             = rand16();
    r.func        = FUNC_WRITE;
    r.entry_index = idx[INDEX_W-1:0];
    r.entry_angle = a[ANGLE_W-1:0];
    r.entry_lift  = l[VAL_W-1:0];
    r.entry_drag  = d[VAL_W-1:0];
    r.query_angle = q[ANGLE_W-1:0];
    tab_angle[idx] = a;
    loaded[idx]    = 1'b1;
    send_request(r);
  endtask

  // The write fields of a lookup are don't-care, so they carry random bits.
  task automatic look_up(int q);
    req_t r;
    int   a;
    int   l;
    int   d;
    a             = rand16();
    l             = rand16();
    d             = rand16();
    r.func        = FUNC_LOOKUP;
    r.entry_index = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
    r.entry_angle = a[ANGLE_W-1:0];
    r.entry_lift  = l[VAL_W-1:0];
    r.entry_drag  = d[VAL_W-1:0];
    r.query_angle = q[ANGLE_W-1:0];
    send_request(r);
  endtask

  // Holds off new requests until every outstanding result has been taken.
  task automatic settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic program_entries(int unsigned v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Loads entries 0 .. eff-1 with ascending angles. Either they spread over the whole format
  // with the extremes at both ends, or they climb from a random start in random steps of a
  // random scale. Now and then a step is zero, which gives equal neighboring angles.
  task automatic load_sorted(int eff);
    int          a;
    int unsigned span;
    bit          full_span;
    full_span = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: span = 1;
      1: span = 16;
      2: span = 300;
      default: span = 1000;
    endcase
    a = -32768 + int'($urandom_range(0, 65535 - (eff - 1) * span));
    for (int i = 0; i < eff; i++) begin
      if (full_span) begin
        a = (eff == 1) ? -32768 : -32768 + (65535 * i) / (eff - 1);
      end else if (i > 0 && $urandom_range(0, 9) != 0) begin
        a = a + int'($urandom_range(1, span));
      end
      load_entry(i, a, pick_value(), pick_value());
    end
  endtask

  // Timeout, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned cfg;
    int          eff;
    int unsigned shape;
    int unsigned looks;
    int unsigned random_start;
    int unsigned phase;
    int unsigned unsorted_phases;
    int unsigned leftover;
    bit          all_loaded;
    bit          messy;

    // Every input of the block gets a known value before the first clock edge.
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_WRITE;
    req_if.entry_index = '0;
    req_if.entry_angle = '0;
    req_if.entry_lift  = '0;
    req_if.entry_drag  = '0;
    req_if.query_angle = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = '0;
    rsp_if.ready       = 1'b0;
    rsp_cycle          = 0;
    stall_mode         = 0;
    mode_left          = 0;
    items_sent         = 0;
    burst_left         = 0;
    unsorted_phases    = 0;
    messy              = 1'b0;
    foreach (loaded[i]) loaded[i] = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening. With one entry in use, the first write must go to entry 0, since
    // every result reports the largest lift over the entries in use.
    program_entries(1);
    load_entry(0, -32768, 32767, -32768);
    // A single entry: any query is clamped onto it and the first entry is returned.
    look_up(32767);
    look_up(-32768);
    // Entries 1 to 4 hold an angle equal to entry 0's, a full-scale step of both curves
    // and the top of the angle range.
    load_entry(1, -32768, -32768, 32767);
    load_entry(2, 0, 100, -100);
    load_entry(3, 256, 32767, -32768);
    load_entry(4, 32767, -32768, 32767);
    settle();
    program_entries(5);
    // At the first angle, just above the equal pair, exactly on a breakpoint,
    // inside a full-scale segment and at the top of the range.
    look_up(-32768);
    look_up(-32767);
    look_up(0);
    look_up(128);
    look_up(255);
    look_up(32767);
    look_up(20000);
    // Breaking the order: entry 3 drops below entry 2, and then the last entry below the
    // first, so the clamp raises the query to the first angle and then lowers it to the last.
    load_entry(3, -100, 4096, 4096);
    look_up(-50);
    look_up(200);
    load_entry(0, 1000, -4096, 8191);
    load_entry(4, -1000, 12288, -1);
    look_up(0);

    // Random phases. Each one readies a table for its entry count under the count still in
    // force, waits until the block is idle, programs the new count and runs a run of lookups.
    // The first three phases fill the whole table and then visit the extreme counts.
    random_start = items_sent;
    phase        = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (phase == 0) begin
        cfg = TABLE_DEPTH;
      end else if (phase == 1) begin
        cfg = 127;
      end else if (phase == 2) begin
        cfg = 0;
      end else begin
        case ($urandom_range(0, 19))
          0: cfg = 0;
          1: cfg = 1;
          2: cfg = TABLE_DEPTH;
          3: cfg = $urandom_range(TABLE_DEPTH + 1, 127);
          4, 5: cfg = $urandom_range(21, TABLE_DEPTH - 1);
          6, 7, 8, 9: cfg = $urandom_range(9, 20);
          default: cfg = $urandom_range(2, 8);
        endcase
      end
      eff = (cfg == 0) ? 1 : ((cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg));

      all_loaded = 1'b1;
      for (int i = 0; i < eff; i++) begin
        if (!loaded[i]) all_loaded = 1'b0;
      end
      shape = $urandom_range(0, 9);
      if (all_loaded && shape < 2) begin
        // Reuse whatever the table holds now.
      end else if (shape < 4 && phase > 2) begin
        for (int i = 0; i < eff; i++) load_entry(i, rand16(), pick_value(), pick_value());
        messy = 1'b1;
        unsorted_phases++;
      end else begin
        load_sorted(eff);
        messy = 1'b0;
      end

      settle();
      program_entries(cfg);

      // Unsorted phases mix in writes to any entry; sorted ones only rarely touch an entry
      // outside the range in use, which leaves the curve intact.
      looks = $urandom_range(6, 30);
      for (int k = 0; k < looks; k++) begin
        if (messy && $urandom_range(0, 4) == 0) begin
          load_entry($urandom_range(0, TABLE_DEPTH - 1), rand16(), pick_value(), pick_value());
        end else if (!messy && eff < TABLE_DEPTH && $urandom_range(0, 19) == 0) begin
          load_entry($urandom_range(eff, TABLE_DEPTH - 1), rand16(), pick_value(),
                     pick_value());
        end else begin
          look_up(pick_query(eff));
        end
      end
      phase++;
    end

    // Drain: wait for the last results, then a lookup's worth of cycles for any stray one.
    @(negedge clk);
    req_if.valid <= 1'b0;
    for (int i = 0; i < 4000 && sb.outstanding() != 0; i++) @(posedge clk);
    repeat (150) @(posedge clk);
    leftover = sb.outstanding();
    if (leftover != 0) $display("tb: %0d expected results never arrived", leftover);

    $display("tb: %0d results checked: %0d table writes and %0d lookups, %0d interpolated",
             sb.results_seen, sb.writes_seen, sb.lookups_seen, sb.blended);
    $display("tb: %0d random table settings, %0d of them unsorted, entry counts 0 to 127",
             phase, unsorted_phases);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
